// File: rtl/core/ats_pkg.sv
`default_nettype none

package ats_pkg;

	typedef logic [3:0] kind_t;

	localparam kind_t KIND_COMMA     = 4'd0;
	localparam kind_t KIND_COMMENT   = 4'd1;
	localparam kind_t KIND_REG       = 4'd2;
	localparam kind_t KIND_SECTION   = 4'd3;
	localparam kind_t KIND_XOR       = 4'd4;
	localparam kind_t KIND_SYSCALL   = 4'd5;
	localparam kind_t KIND_MOV       = 4'd6;
	localparam kind_t KIND_GLOBAL    = 4'd7;
	localparam kind_t KIND_LABEL     = 4'd8;
	localparam kind_t KIND_DIRECTIVE = 4'd9;
	localparam kind_t KIND_IDENT     = 4'd10;
	localparam kind_t KIND_INT       = 4'd11;
	localparam kind_t KIND_ERROR     = 4'd12;
	localparam kind_t KIND_END       = 4'd13;
	// no keyword matched (comma never comes out of the keyword table)
	localparam kind_t KIND_NO_KW     = KIND_COMMA;

	localparam int OUT_POS_W = 32;

	typedef struct packed {
		kind_t                kind;
		logic [OUT_POS_W-1:0] line_no;
		logic [OUT_POS_W-1:0] start_col;
		logic [OUT_POS_W-1:0] end_col;
		logic                 had_error;
		logic                 last;
	} res_t;

	// result queue
	localparam int RES_DEPTH = 4;
	localparam int RES_PTR_W = $clog2(RES_DEPTH);
	localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

	// keyword table, text held first character in the lowest byte
	localparam int KW_MAX_LEN = 7;
	localparam int KW_TEXT_W  = 8 * KW_MAX_LEN;
	localparam int KW_LEN_W   = 3;
	localparam int KW_COUNT   = 13;

	typedef struct packed {
		logic [KW_TEXT_W-1:0] text;
		logic [KW_LEN_W-1:0]  len;
		kind_t                kind;
	} kw_t;

	localparam kw_t KW_TABLE [KW_COUNT] = '{
		'{KW_TEXT_W'("idr"),     3'd3, KIND_REG},
		'{KW_TEXT_W'("xar"),     3'd3, KIND_REG},
		'{KW_TEXT_W'("ide"),     3'd3, KIND_REG},
		'{KW_TEXT_W'("xae"),     3'd3, KIND_REG},
		'{KW_TEXT_W'("id"),      3'd2, KIND_REG},
		'{KW_TEXT_W'("xa"),      3'd2, KIND_REG},
		'{KW_TEXT_W'("lid"),     3'd3, KIND_REG},
		'{KW_TEXT_W'("la"),      3'd2, KIND_REG},
		'{KW_TEXT_W'("noitces"), 3'd7, KIND_SECTION},
		'{KW_TEXT_W'("rox"),     3'd3, KIND_XOR},
		'{KW_TEXT_W'("llacsys"), 3'd7, KIND_SYSCALL},
		'{KW_TEXT_W'("vom"),     3'd3, KIND_MOV},
		'{KW_TEXT_W'("labolg"),  3'd6, KIND_GLOBAL}
	};

	function automatic kind_t kw_lookup(input logic [KW_TEXT_W-1:0] text,
			input logic [KW_LEN_W-1:0] n);
		kind_t k;
		k = KIND_NO_KW;
		for (int i = KW_COUNT - 1; i >= 0; i--) begin
			if (KW_TABLE[i].len == n && KW_TABLE[i].text == text) begin
				k = KW_TABLE[i].kind;
			end
		end
		return k;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/assembly_token_scanner.sv
// Streaming assembly tokenizer. One source byte (or an end-of-text marker in
// s_tuser) is taken per cycle; the scan state (mode, line, column, word
// buffer) updates in the cycle of the request and each request yields zero,
// one or two results, which leave through a four-entry result queue at one
// per cycle. A new request is taken whenever the queue has room for two
// results, so the input runs at one byte per cycle as long as results are
// drained about as fast as they arise; two-result requests (a token ended by
// a comma or unknown byte, any flush on end of text) leave one more result
// to drain. The last result of each request has m_tlast set. Line and
// column saturate at POS_WIDTH bits and are reported in their low 32 bits.
`default_nettype none

module assembly_token_scanner
	import ats_pkg::*;
#(
	parameter int POS_WIDTH     = 32,
	parameter int KEYWORD_CHARS = 7
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	input  wire  [7:0]   s_tdata,   // ch
	input  wire          s_tuser,   // end_of_text
	output logic         m_tvalid,
	input  wire          m_tready,
	output logic [103:0] m_tdata,   // line_no, start_col, end_col, had_error, zero pad
	output logic [3:0]   m_tuser,   // kind
	output logic         m_tlast
);

	localparam int LEN_W  = $clog2(KEYWORD_CHARS + 2);
	localparam int IDX_W  = $clog2(KEYWORD_CHARS);
	localparam int CHR_W  = 8 * KEYWORD_CHARS;
	localparam int EXT_W  = (POS_WIDTH > OUT_POS_W) ? POS_WIDTH : OUT_POS_W;

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_UNDER = 8'h5F;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_WORD,
		MODE_NUM,
		MODE_COMMENT
	} mode_t;

	mode_t                mode_q, mode_n;
	logic [POS_WIDTH-1:0] line_q, line_n;
	logic [POS_WIDTH-1:0] col_q, col_n;
	logic [POS_WIDTH-1:0] start_q, start_n;
	logic [CHR_W-1:0]     chars_q, chars_n;
	logic [LEN_W-1:0]     len_q, len_n;
	logic                 dot_q, dot_n;
	logic                 err_q, err_n;

	logic                 accept;
	logic [7:0]           ch;
	logic                 eot;
	logic                 is_letter, is_digit, is_word_ch;
	logic [POS_WIDTH-1:0] col_inc;
	kind_t                kw_kind;
	logic                 kw_hit;
	kind_t                word_kind;
	kind_t                pend_kind;

	logic                 flush_v, idle_v, idle_go;
	res_t                 flush_r, idle_r;
	logic                 push0, push1;
	res_t                 r0, r1;
	logic                 room2;
	res_t                 head;

	function automatic logic [OUT_POS_W-1:0] pos_out(input logic [POS_WIDTH-1:0] v);
		logic [EXT_W-1:0] w;
		w = EXT_W'(v);
		return w[OUT_POS_W-1:0];
	endfunction

	function automatic logic [POS_WIDTH-1:0] sat_inc(input logic [POS_WIDTH-1:0] v);
		return (v == '1) ? v : v + POS_WIDTH'(1);
	endfunction

	assign accept = s_tvalid && s_tready;
	assign s_tready = room2;
	assign ch  = s_tdata;
	assign eot = s_tuser;

	assign is_letter  = (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A);
	assign is_digit   = (ch >= 8'h30 && ch <= 8'h39);
	assign is_word_ch = is_letter || is_digit || ch == CH_UNDER || ch == CH_DOT;
	assign col_inc    = sat_inc(col_q);

	// words longer than the keyword buffer never match
	assign kw_kind   = kw_lookup(chars_q[KW_TEXT_W-1:0], len_q[KW_LEN_W-1:0]);
	assign kw_hit    = (len_q <= LEN_W'(KW_MAX_LEN)) && (kw_kind != KIND_NO_KW);
	assign word_kind = kw_hit ? kw_kind : (dot_q ? KIND_DIRECTIVE : KIND_IDENT);

	always_comb begin
		unique case (mode_q)
			MODE_WORD:    pend_kind = word_kind;
			MODE_NUM:     pend_kind = KIND_INT;
			MODE_COMMENT: pend_kind = KIND_COMMENT;
			default:      pend_kind = KIND_NO_KW;
		endcase
	end

	always_comb begin
		mode_n  = mode_q;
		line_n  = line_q;
		col_n   = col_q;
		start_n = start_q;
		chars_n = chars_q;
		len_n   = len_q;
		dot_n   = dot_q;
		err_n   = err_q;
		idle_go = 1'b0;

		flush_v           = 1'b0;
		flush_r.kind      = pend_kind;
		flush_r.line_no   = pos_out(line_q);
		flush_r.start_col = pos_out(start_q);
		flush_r.end_col   = pos_out(col_q);
		flush_r.had_error = 1'b0;
		flush_r.last      = 1'b0;

		idle_v           = 1'b0;
		idle_r.kind      = KIND_ERROR;
		idle_r.line_no   = pos_out(line_q);
		idle_r.start_col = pos_out(col_q);
		idle_r.end_col   = pos_out(col_q);
		idle_r.had_error = 1'b0;
		idle_r.last      = 1'b0;

		if (eot) begin
			flush_v          = (mode_q != MODE_IDLE);
			idle_v           = 1'b1;
			idle_r.kind      = KIND_END;
			idle_r.had_error = err_q;
			mode_n  = MODE_IDLE;
			line_n  = POS_WIDTH'(1);
			col_n   = POS_WIDTH'(1);
			start_n = '0;
			chars_n = '0;
			len_n   = '0;
			dot_n   = 1'b0;
			err_n   = 1'b0;
		end else begin
			unique case (mode_q)
				MODE_WORD: begin
					if (is_word_ch) begin
						if (len_q < LEN_W'(KEYWORD_CHARS)) begin
							chars_n[8 * len_q[IDX_W-1:0] +: 8] = ch;
						end
						if (len_q <= LEN_W'(KEYWORD_CHARS)) begin
							len_n = len_q + LEN_W'(1);
						end
						col_n = col_inc;
					end else if (ch == CH_COLON && !kw_hit) begin
						// label takes the colon
						flush_v         = 1'b1;
						flush_r.kind    = KIND_LABEL;
						flush_r.end_col = pos_out(col_inc);
						col_n           = col_inc;
						mode_n          = MODE_IDLE;
					end else begin
						flush_v = 1'b1;
						mode_n  = MODE_IDLE;
						idle_go = 1'b1;
					end
				end
				MODE_NUM: begin
					if (is_digit) begin
						col_n = col_inc;
					end else begin
						flush_v = 1'b1;
						mode_n  = MODE_IDLE;
						idle_go = 1'b1;
					end
				end
				MODE_COMMENT: begin
					if (ch == CH_NL) begin
						flush_v = 1'b1;
						mode_n  = MODE_IDLE;
						idle_go = 1'b1;
					end else begin
						col_n = col_inc;
					end
				end
				MODE_IDLE: begin
					idle_go = 1'b1;
				end
			endcase

			// byte seen from idle; a flush that hands its byte on here never moves the column
			if (idle_go) begin
				if (ch == CH_NL) begin
					line_n = sat_inc(line_q);
					col_n  = POS_WIDTH'(1);
				end else if (ch == CH_SPACE || ch == CH_TAB) begin
					col_n = col_inc;
				end else if (ch == CH_COMMA) begin
					idle_v      = 1'b1;
					idle_r.kind = KIND_COMMA;
					col_n       = col_inc;
				end else if (ch == CH_SEMI) begin
					mode_n  = MODE_COMMENT;
					start_n = col_q;
					col_n   = col_inc;
				end else if (is_letter || ch == CH_UNDER || ch == CH_DOT) begin
					mode_n       = MODE_WORD;
					start_n      = col_q;
					chars_n      = '0;
					chars_n[7:0] = ch;
					len_n        = LEN_W'(1);
					dot_n        = (ch == CH_DOT);
					col_n        = col_inc;
				end else if (is_digit) begin
					mode_n  = MODE_NUM;
					start_n = col_q;
					col_n   = col_inc;
				end else begin
					idle_v = 1'b1;
					err_n  = 1'b1;
					col_n  = col_inc;
				end
			end
		end
	end

	// pack up to two results, the later one closing the request
	always_comb begin
		push0 = accept && (flush_v || idle_v);
		push1 = accept && flush_v && idle_v;
		r0    = flush_v ? flush_r : idle_r;
		r1    = idle_r;
		r0.last = !(flush_v && idle_v);
		r1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			line_q  <= POS_WIDTH'(1);
			col_q   <= POS_WIDTH'(1);
			start_q <= '0;
			chars_q <= '0;
			len_q   <= '0;
			dot_q   <= 1'b0;
			err_q   <= 1'b0;
		end else if (accept) begin
			mode_q  <= mode_n;
			line_q  <= line_n;
			col_q   <= col_n;
			start_q <= start_n;
			chars_q <= chars_n;
			len_q   <= len_n;
			dot_q   <= dot_n;
			err_q   <= err_n;
		end
	end

	ats_res_fifo u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push0     (push0),
		.push1     (push1),
		.din0      (r0),
		.din1      (r1),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.dout      (head),
		.room2     (room2)
	);

	assign m_tdata = {7'b0, head.had_error, head.end_col, head.start_col, head.line_no};
	assign m_tuser = head.kind;
	assign m_tlast = head.last;

`ifndef NO_ASSERTIONS
	a_eot_resets: assert property (@(posedge clk) disable iff (!arst_n)
		accept && eot |=> mode_q == MODE_IDLE && line_q == POS_WIDTH'(1)
			&& col_q == POS_WIDTH'(1) && !err_q)
		else $error("end of text did not return the scanner to its start state");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		push1 |-> push0 && !r0.last && r1.last && r1.kind != KIND_LABEL)
		else $error("two results of one request badly ordered");

	a_col_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		col_q != '0 && line_q != '0)
		else $error("line or column reached zero");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push0 |-> room2)
		else $error("result pushed without queue room");
`endif

endmodule

`default_nettype wire

// File: rtl/core/ats_res_fifo.sv
`default_nettype none

module ats_res_fifo
	import ats_pkg::*;
(
	input  wire       clk,
	input  wire       arst_n,
	input  wire       push0,
	input  wire       push1,
	input  wire res_t din0,
	input  wire res_t din1,
	input  wire       out_ready,
	output logic      out_valid,
	output res_t      dout,
	output logic      room2
);

	res_t                 mem_q [RES_DEPTH];
	logic [RES_PTR_W-1:0] wr_q;
	logic [RES_PTR_W-1:0] rd_q;
	logic [RES_CNT_W-1:0] count_q;
	logic                 pop;
	logic [RES_CNT_W-1:0] n_push;
	logic [RES_PTR_W-1:0] wr_p1;

	assign out_valid = (count_q != '0);
	assign dout      = mem_q[rd_q];
	assign pop       = out_ready && out_valid;
	assign room2     = (count_q <= RES_CNT_W'(RES_DEPTH - 2));
	assign n_push    = RES_CNT_W'(push0) + RES_CNT_W'(push1);
	assign wr_p1     = wr_q + RES_PTR_W'(1);

	always_ff @(posedge clk) begin
		if (push0) begin
			mem_q[wr_q] <= din0;
		end
		if (push1) begin
			mem_q[wr_p1] <= din1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + RES_PTR_W'(n_push);
			if (pop) begin
				rd_q <= rd_q + RES_PTR_W'(1);
			end
			count_q <= count_q + n_push - RES_CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import ats_pkg::*;

	typedef enum logic [1:0] {SCAN_IDLE, SCAN_WORD, SCAN_NUM, SCAN_COMMENT} scan_t;

	localparam logic [31:0] POS_SAT   = 32'hFFFF_FFFF;
	localparam int          WORD_KEEP = 7;
	localparam int          NUM_KW    = 13;
	localparam int          NUM_BYTES = 1550;
	localparam int          HOLD_AT   = 300;
	localparam int          HOLD_LEN  = 80;
	localparam logic [7:0]  CH_LF     = 8'h0A;
	localparam logic [7:0]  CH_TAB    = 8'h09;
	localparam logic [7:0]  CH_CR     = 8'h0D;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = 8'h00;   // ch
	logic         s_tuser = 1'b0;    // end_of_text
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [103:0] m_tdata;           // line_no, start_col, end_col, had_error, zero pad
	logic [3:0]   m_tuser;           // kind
	logic         m_tlast;

	assembly_token_scanner DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	string kw_text [NUM_KW] = '{"rdi", "rax", "edi", "eax", "di", "ax", "dil", "al",
		"section", "xor", "syscall", "mov", "global"};
	kind_t kw_kind [NUM_KW] = '{KIND_REG, KIND_REG, KIND_REG, KIND_REG, KIND_REG, KIND_REG,
		KIND_REG, KIND_REG, KIND_SECTION, KIND_XOR, KIND_SYSCALL, KIND_MOV, KIND_GLOBAL};

	// scanner state mirrored from the accepted requests
	scan_t       mode;
	logic [31:0] line_cnt;
	logic [31:0] col;
	logic [31:0] tok_start;
	logic [7:0]  word_buf [WORD_KEEP];
	logic [3:0]  word_len;
	logic        dot_word;
	logic        err_seen;

	res_t        step_out [2];
	int          n_out;
	res_t        token_q [$];
	logic [8:0]  byte_q [$];         // {end_of_text, ch}

	int          bytes_taken = 0;
	int          tokens_due = 0;
	int          total_bytes = 0;
	logic        failed = 1'b0;

	function automatic logic [31:0] bump(input logic [31:0] v);
		return (v == POS_SAT) ? v : v + 32'd1;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_num(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_word_char(input logic [7:0] c);
		return is_alpha(c) || is_num(c) || c == "_" || c == ".";
	endfunction

	function automatic kind_t keyword_of();
		kind_t k;
		logic  hit;
		k = KIND_NO_KW;
		for (int i = 0; i < NUM_KW; i++) begin
			hit = (kw_text[i].len() == word_len) && (word_len <= WORD_KEEP);
			for (int j = 0; j < kw_text[i].len(); j++) begin
				if (hit && kw_text[i][j] != word_buf[j])
					hit = 1'b0;
			end
			if (hit && k == KIND_NO_KW)
				k = kw_kind[i];
		end
		return k;
	endfunction

	function automatic kind_t word_class();
		kind_t k;
		k = keyword_of();
		if (k != KIND_NO_KW)
			return k;
		return dot_word ? KIND_DIRECTIVE : KIND_IDENT;
	endfunction

	task automatic clear_scanner();
		mode = SCAN_IDLE;
		line_cnt = 32'd1;
		col = 32'd1;
		tok_start = 32'd0;
		for (int i = 0; i < WORD_KEEP; i++)
			word_buf[i] = 8'h00;
		word_len = 4'd0;
		dot_word = 1'b0;
		err_seen = 1'b0;
	endtask

	task automatic emit(input kind_t k, input logic [31:0] s, input logic [31:0] e,
			input logic err);
		res_t r;
		if (n_out < 2) begin
			r.kind = k;
			r.line_no = line_cnt;
			r.start_col = s;
			r.end_col = e;
			r.had_error = err;
			r.last = 1'b0;
			step_out[n_out] = r;
			n_out++;
		end
	endtask

	task automatic close_token();
		case (mode)
			SCAN_WORD: emit(word_class(), tok_start, col, 1'b0);
			SCAN_NUM: emit(KIND_INT, tok_start, col, 1'b0);
			SCAN_COMMENT: emit(KIND_COMMENT, tok_start, col, 1'b0);
			default: ;
		endcase
		mode = SCAN_IDLE;
	endtask

	task automatic from_idle(input logic [7:0] c);
		if (c == CH_LF) begin
			line_cnt = bump(line_cnt);
			col = 32'd1;
		end else if (c == " " || c == CH_TAB) begin
			col = bump(col);
		end else if (c == ",") begin
			emit(KIND_COMMA, col, col, 1'b0);
			col = bump(col);
		end else if (c == ";") begin
			mode = SCAN_COMMENT;
			tok_start = col;
			col = bump(col);
		end else if (is_alpha(c) || c == "_" || c == ".") begin
			mode = SCAN_WORD;
			tok_start = col;
			for (int i = 0; i < WORD_KEEP; i++)
				word_buf[i] = 8'h00;
			word_buf[0] = c;
			word_len = 4'd1;
			dot_word = (c == ".");
			col = bump(col);
		end else if (is_num(c)) begin
			mode = SCAN_NUM;
			tok_start = col;
			col = bump(col);
		end else begin
			emit(KIND_ERROR, col, col, 1'b0);
			err_seen = 1'b1;
			col = bump(col);
		end
	endtask

	task automatic scan_byte(input logic [7:0] c, input logic eot);
		res_t r;
		n_out = 0;
		if (eot) begin
			close_token();
			emit(KIND_END, col, col, err_seen);
			clear_scanner();
		end else begin
			case (mode)
				SCAN_WORD: begin
					if (is_word_char(c)) begin
						if (word_len < WORD_KEEP)
							word_buf[word_len] = c;
						if (word_len <= WORD_KEEP)
							word_len = word_len + 4'd1;
						col = bump(col);
					end else if (c == ":" && keyword_of() == KIND_NO_KW) begin
						// label swallows the colon
						col = bump(col);
						emit(KIND_LABEL, tok_start, col, 1'b0);
						mode = SCAN_IDLE;
					end else begin
						close_token();
						from_idle(c);
					end
				end
				SCAN_NUM: begin
					if (is_num(c)) begin
						col = bump(col);
					end else begin
						close_token();
						from_idle(c);
					end
				end
				SCAN_COMMENT: begin
					if (c == CH_LF) begin
						close_token();
						from_idle(c);
					end else begin
						col = bump(col);
					end
				end
				default: from_idle(c);
			endcase
		end
		if (n_out > 0) begin
			r = step_out[n_out - 1];
			r.last = 1'b1;
			step_out[n_out - 1] = r;
		end
		for (int i = 0; i < n_out; i++)
			token_q.insert(token_q.size(), step_out[i]);
		tokens_due += n_out;
	endtask

	task automatic report_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			failed = 1'b1;
		end
	endtask

	task automatic check_token(input res_t got);
		res_t want;
		if (token_q.size() == 0) begin
			$display("%0t: unexpected token kind %0d line %0d cols %0d..%0d", $time,
				got.kind, got.line_no, got.start_col, got.end_col);
			failed = 1'b1;
		end else begin
			want = token_q.pop_front();
			tokens_due--;
			report_field("kind", want.kind, got.kind);
			report_field("line_no", want.line_no, got.line_no);
			report_field("start_col", want.start_col, got.start_col);
			report_field("end_col", want.end_col, got.end_col);
			report_field("had_error", want.had_error, got.had_error);
			report_field("last", want.last, got.last);
		end
	endtask

	// request source

	task automatic put(input logic [7:0] c);
		byte_q.insert(byte_q.size(), {1'b0, c});
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put(s[i]);
	endtask

	task automatic put_end();
		byte_q.insert(byte_q.size(), {1'b1, 8'($urandom_range(255))});
	endtask

	function automatic logic [7:0] word_char(input logic lead);
		int r;
		r = lead ? $urandom_range(53) : $urandom_range(63);
		if (r < 26)
			return 8'("a" + r);
		if (r < 52)
			return 8'("A" + r - 26);
		if (lead)
			return (r == 52) ? "_" : ".";
		if (r < 62)
			return 8'("0" + r - 52);
		return (r == 62) ? "_" : ".";
	endfunction

	task automatic put_tail(input int n);
		for (int i = 0; i < n; i++)
			put(word_char(1'b0));
	endtask

	task automatic put_keyword();
		put_text(kw_text[$urandom_range(NUM_KW - 1)]);
	endtask

	task automatic put_token();
		int r;
		r = $urandom_range(99);
		if (r < 25) begin
			put_keyword();
		end else if (r < 30) begin
			// a colon after a keyword is not a label
			put_keyword();
			put(":");
		end else if (r < 35) begin
			put_keyword();
			put_tail($urandom_range(1, 3));
		end else if (r < 50) begin
			put(word_char(1'b1));
			put_tail($urandom_range(0, 9));
		end else if (r < 62) begin
			put(word_char(1'b1));
			put_tail($urandom_range(0, 8));
			put(":");
		end else if (r < 70) begin
			put(".");
			put_tail($urandom_range(0, 6));
		end else if (r < 82) begin
			for (int i = $urandom_range(1, 6); i > 0; i--)
				put(8'("0" + $urandom_range(9)));
		end else if (r < 88) begin
			put(",");
		end else begin
			put(8'($urandom_range(255)));
		end
	endtask

	task automatic put_gap();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			put(" ");
		else if (r < 75)
			put(CH_TAB);
		else if (r < 85)
			put_text(", ");
		else if (r < 95)
			;
		else
			put_text("  ");
	endtask

	task automatic put_comment();
		logic [7:0] c;
		put(";");
		for (int i = $urandom_range(0, 8); i > 0; i--) begin
			c = 8'($urandom_range(255));
			put((c == CH_LF) ? 8'h20 : c);
		end
	endtask

	task automatic put_program();
		int n_lines;
		n_lines = $urandom_range(1, 6);
		for (int ln = 0; ln < n_lines; ln++) begin
			if ($urandom_range(3) == 0)
				put(CH_TAB);
			for (int t = $urandom_range(1, 5); t > 0; t--) begin
				put_token();
				put_gap();
			end
			if ($urandom_range(9) < 3)
				put_comment();
			// sometimes the text ends with a token still open
			if (ln < n_lines - 1 || $urandom_range(3) != 0)
				put(CH_LF);
		end
		put_end();
	endtask

	function automatic int pick_gap(input logic calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(99);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// request driver
	int   items_sent = 0;
	int   gap_left = 0;
	logic calm_tx = 1'b0;

	always @(negedge clk) begin : drive_requests
		logic [8:0] item;
		if (arst_n && !(s_tvalid && bytes_taken < items_sent)) begin
			if (gap_left > 0) begin
				s_tvalid <= 1'b0;
				gap_left--;
			end else if (byte_q.size() > 0) begin
				item = byte_q.pop_front();
				s_tdata <= item[7:0];
				s_tuser <= item[8];
				s_tvalid <= 1'b1;
				items_sent++;
				gap_left = pick_gap(calm_tx);
				if ($urandom_range(99) == 0)
					calm_tx = !calm_tx;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result receiver, with one long hold-off to back up the input
	int   hold_left = 0;
	logic hold_done = 1'b0;
	int   stall_left = 0;
	logic calm_rx = 1'b0;

	always @(negedge clk) begin
		if (!hold_done && bytes_taken >= HOLD_AT) begin
			hold_done = 1'b1;
			hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
			stall_left = pick_gap(calm_rx);
		end
		if ($urandom_range(299) == 0)
			calm_rx = !calm_rx;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				scan_byte(s_tdata, s_tuser);
				bytes_taken++;
			end
			if (m_tvalid && m_tready)
				check_token({m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[95:64],
					m_tdata[96], m_tlast});
		end
	end

	initial begin
		clear_scanner();
		// keyword before colon, unknown bytes, comments closed by newline and by end
		put_text("mov al:");
		put(8'hFF);
		put(CH_CR);
		put_text(";c\n");
		put_text("_a:.d 09,");
		put(8'h00);
		put_text(";z");
		put_end();
		while (byte_q.size() < NUM_BYTES)
			put_program();
		total_bytes = byte_q.size();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		wait (bytes_taken == total_bytes && tokens_due == 0);
		repeat (20) @(posedge clk);
		if (!failed)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb_top failed");
		$finish;
	end

endmodule
